/* design/linear_adsr_envelope_unit_defines.svh */
// Assertion macros shared by the linear ADSR envelope RTL.
`ifndef LINEAR_ADSR_ENVELOPE_UNIT_DEFINES_SVH
`define LINEAR_ADSR_ENVELOPE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LAE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LAE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define LAE_ASSERT(lbl, prop, msg)
`define LAE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* design/lae_pkg.sv */
// Types, constants and codes shared by the linear ADSR envelope modules.
package lae_pkg;

    localparam int FRAC_BITS      = 23;
    localparam int DAC_FULL_SCALE = 4095;

    localparam int LEVEL_W    = 24;
    localparam int TICKS_W    = 16;
    localparam int DAC_W      = 12;
    localparam int DAC_MULT_W = 16;
    localparam int PROD_W     = LEVEL_W + DAC_MULT_W;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - LEVEL_W - DAC_W - 2;

    localparam int DIV_STEPS = LEVEL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [LEVEL_W-1:0] ENV_ONE = LEVEL_W'(1) << FRAC_BITS;

    localparam logic [LEVEL_W-1:0] RST_ATTACK_STEP   = LEVEL_W'(27962);
    localparam logic [LEVEL_W-1:0] RST_DECAY_STEP    = LEVEL_W'(13981);
    localparam logic [LEVEL_W-1:0] RST_SUSTAIN_LEVEL = LEVEL_W'(4194304);
    localparam logic [TICKS_W-1:0] RST_RELEASE_TICKS = TICKS_W'(300);

    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY   = 2'd1,
        PH_SUSTAIN = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ATTACK_STEP   = 2'd0,
        CFG_DECAY_STEP    = 2'd1,
        CFG_SUSTAIN_LEVEL = 2'd2,
        CFG_RELEASE_TICKS = 2'd3
    } t_cfg_addr;

    typedef struct packed {
        logic [LEVEL_W-1:0] attack_step;
        logic [LEVEL_W-1:0] decay_step;
        logic [LEVEL_W-1:0] sustain_level;
        logic [TICKS_W-1:0] release_ticks;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* design/lae_regs.sv */
// Configuration register file of the linear ADSR envelope.
module lae_regs import lae_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_step   <= RST_ATTACK_STEP;
            r_cfg.decay_step    <= RST_DECAY_STEP;
            r_cfg.sustain_level <= RST_SUSTAIN_LEVEL;
            r_cfg.release_ticks <= RST_RELEASE_TICKS;
        end else if (i_cfg_we) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_ATTACK_STEP:   r_cfg.attack_step   <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_DECAY_STEP:    r_cfg.decay_step    <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_SUSTAIN_LEVEL: r_cfg.sustain_level <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_RELEASE_TICKS: r_cfg.release_ticks <= i_cfg_wdata[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/lae_div.sv */
// Bit-serial restoring divider that forms the release slope, one quotient bit per cycle.
`include "linear_adsr_envelope_unit_defines.svh"
module lae_div import lae_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [LEVEL_W-1:0] i_dividend,
    input  logic [TICKS_W-1:0] i_divisor,
    output t_div_stat          o_stat,
    output logic [LEVEL_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_count;
    logic [LEVEL_W-1:0]   r_quot;
    logic [TICKS_W-1:0]   r_rem;
    logic [TICKS_W-1:0]   r_divisor;

    logic [TICKS_W:0]     w_shifted;
    logic [TICKS_W:0]     w_diff;
    logic                 w_fits;

    assign w_shifted = {r_rem, r_quot[LEVEL_W-1]};
    assign w_diff    = w_shifted - {1'b0, r_divisor};
    assign w_fits    = (w_shifted >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_count   <= '0;
                r_quot    <= i_dividend;
                r_rem     <= '0;
                r_divisor <= i_divisor;
            end else if (r_busy) begin
                r_rem   <= w_fits ? w_diff[TICKS_W-1:0] : w_shifted[TICKS_W-1:0];
                r_quot  <= {r_quot[LEVEL_W-2:0], w_fits};
                r_count <= r_count + DIV_CNT_W'(1);
                if (r_count == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quot;

    `LAE_ASSERT(a_start_when_idle, i_start |-> !r_busy, "divider started while busy")
    `LAE_ASSERT(a_done_ends_busy, r_done |-> ($past(r_busy) && !r_busy), "done without a run")
    `LAE_ASSERT(a_count_range, r_busy |-> (r_count < DIV_CNT_W'(DIV_STEPS)), "step count overrun")

endmodule

/* design/linear_adsr_envelope_unit.sv */
// Top level of the linear ADSR envelope generator with one result per tick.
// A tick is accepted, and its result registered, in the same cycle; the result shows the next cycle.
// A gate-off tick that leaves attack, decay or sustain also starts the release-slope division
// in the serial divider; no tick is accepted until that division ends.
// Every other tick sustains one per cycle while the output is drained.
// Synchronous active-low reset restores register defaults, release phase and zero level.
`include "linear_adsr_envelope_unit_defines.svh"
module linear_adsr_envelope_unit import lae_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] gate
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // [23:0] level, [35:24] dac_code, [37:36] phase
);

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } t_state;

    t_cfg               w_cfg;
    t_div_stat          w_div_stat;
    logic [LEVEL_W-1:0] w_quotient;
    logic               w_div_start;
    logic [TICKS_W-1:0] w_ticks;

    t_state             r_state,     n_state;
    t_phase             r_phase,     n_phase;
    logic [LEVEL_W-1:0] r_level,     n_level;
    logic [LEVEL_W-1:0] r_slope,     n_slope;
    logic               r_out_valid, n_out_valid;
    logic [LEVEL_W-1:0] r_out_level, n_out_level;
    t_phase             r_out_phase, n_out_phase;

    logic               w_in_fire;
    logic               w_out_fire;
    logic               w_gate;
    logic [LEVEL_W-1:0] w_sus;
    logic [LEVEL_W:0]   w_att_sum;
    logic [LEVEL_W-1:0] w_att_level;
    logic [LEVEL_W-1:0] w_dec_level;
    logic [LEVEL_W-1:0] w_rel_level;
    logic [PROD_W-1:0]  w_dac_prod;

    lae_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    lae_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_level),
        .i_divisor  (w_ticks),
        .o_stat     (w_div_stat),
        .o_quotient (w_quotient)
    );

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_fire    = m_axis_tvalid && m_axis_tready;
    assign w_gate        = s_axis_tdata[0];

    assign w_sus       = (w_cfg.sustain_level > ENV_ONE) ? ENV_ONE : w_cfg.sustain_level;
    assign w_att_sum   = {1'b0, r_level} + {1'b0, w_cfg.attack_step};
    assign w_att_level = (w_att_sum > {1'b0, ENV_ONE}) ? ENV_ONE : w_att_sum[LEVEL_W-1:0];
    assign w_dec_level = (r_level > w_cfg.decay_step) ? (r_level - w_cfg.decay_step) : '0;
    assign w_rel_level = (r_level > r_slope) ? (r_level - r_slope) : '0;
    assign w_ticks     = (w_cfg.release_ticks == '0) ? TICKS_W'(1) : w_cfg.release_ticks;
    assign w_div_start = w_in_fire && !w_gate && (r_phase != PH_RELEASE);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_level     = r_level;
        n_slope     = r_slope;
        n_out_valid = r_out_valid;
        n_out_level = r_out_level;
        n_out_phase = r_out_phase;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    if (w_gate) begin
                        unique case (r_phase)
                            PH_ATTACK: begin
                                if (r_level >= ENV_ONE) begin
                                    n_level = ENV_ONE;
                                    n_phase = PH_DECAY;
                                end else begin
                                    n_level = w_att_level;
                                end
                            end
                            PH_DECAY: begin
                                if (r_level <= w_sus) begin
                                    n_level = w_sus;
                                    n_phase = PH_SUSTAIN;
                                end else begin
                                    n_level = w_dec_level;
                                end
                            end
                            PH_SUSTAIN: n_level = w_sus;
                            PH_RELEASE: begin
                                n_level = '0;
                                n_phase = PH_ATTACK;
                            end
                            default: ;
                        endcase
                    end else if (r_phase != PH_RELEASE) begin
                        n_phase = PH_RELEASE;
                        n_state = ST_DIV;
                    end else begin
                        n_level = w_rel_level;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_stat.done) begin
                    n_slope = ((w_quotient == '0) && (r_level != '0)) ?
                              LEVEL_W'(1) : w_quotient;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (w_out_fire) begin
            n_out_valid = 1'b0;
        end
        if (w_in_fire) begin
            n_out_valid = 1'b1;
            n_out_level = n_level;
            n_out_phase = n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_RELEASE;
            r_level     <= '0;
            r_slope     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_level     <= n_level;
            r_slope     <= n_slope;
            r_out_valid <= n_out_valid;
        end
        r_out_level <= n_out_level;
        r_out_phase <= n_out_phase;
    end

    assign w_dac_prod    = {{DAC_MULT_W{1'b0}}, r_out_level} * PROD_W'(DAC_FULL_SCALE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_phase, w_dac_prod[FRAC_BITS +: DAC_W],
                            r_out_level};

    `LAE_ASSERT(a_level_max, r_level <= ENV_ONE, "level above full scale")
    `LAE_ASSERT(a_busy_stalls, w_div_stat.busy |-> !s_axis_tready, "tick taken during division")
    `LAE_ASSERT(a_slope_set,
        (r_state == ST_IDLE && r_phase == PH_RELEASE && r_level != '0) |-> (r_slope != '0),
        "release with zero slope")

endmodule
